### rtl/base64_stream_encoder_assert.svh
// Assertion macros shared by the checker files of the encoder.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// An antecedent that holds at an edge implies the consequent property.
`define B64E_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// An antecedent that holds at an edge implies the consequent by non-overlapping implication.
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the alphabet lookup shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   // Position of the next byte within a three-byte group.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // Characters produced by one byte, handed from the front to the back.
   typedef struct packed {
      logic [3:0][6:0] chars;     // chars[0] goes out first
      logic [1:0]      last_idx;  // index of the final character of the run
      logic            final_msg; // final character also ends the message
   } job_type;

   // Reversed alphabet: index 0 is '/', 1 is '+', then '9'..'0', 'z'..'a', 'Z'..'A'.
   function automatic logic [6:0] symbol_of(input logic [5:0] idx);
      logic [7:0] wide;
      begin
         wide = 8'h00;
         if (idx == 6'd0) begin
            wide = 8'h2F;
         end else if (idx == 6'd1) begin
            wide = 8'h2B;
         end else if (idx < 6'd12) begin
            wide = 8'h3B - {2'b00, idx};
         end else if (idx < 6'd38) begin
            wide = 8'h86 - {2'b00, idx};
         end else begin
            wide = 8'h80 - {2'b00, idx};
         end
         symbol_of = wide[6:0];
      end
   endfunction

endpackage

`default_nettype wire

### rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts input bytes, tracks the group position and leftover bits, and
// turns each byte into the run of characters it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             byte_valid,
   output logic                  byte_ready,
   input  wire logic [7:0]       data_byte,
   input  wire logic             is_final,
   output logic                  job_push,
   output b64e_pkg::job_type     job_data,
   input  wire logic             job_full
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          leftover_ff, leftover_in;
   logic                take;

   assign byte_ready = !job_full;
   assign take       = byte_valid && !job_full;
   assign job_push   = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64e_pkg::PH_FIRST;
         leftover_ff <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

   // Next group position and leftover bits.
   always_comb begin
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      if (take) begin
         if (is_final) begin
            phase_in    = b64e_pkg::PH_FIRST;
            leftover_in = 4'd0;
         end else begin
            case (phase_ff)
               b64e_pkg::PH_SECOND: begin
                  phase_in    = b64e_pkg::PH_THIRD;
                  leftover_in = data_byte[3:0];
               end
               b64e_pkg::PH_THIRD: begin
                  phase_in    = b64e_pkg::PH_FIRST;
                  leftover_in = 4'd0;
               end
               default: begin
                  phase_in    = b64e_pkg::PH_SECOND;
                  leftover_in = {2'b00, data_byte[1:0]};
               end
            endcase
         end
      end
   end

   // Characters for the current byte; a final byte flushes and pads the group.
   always_comb begin
      job_data.chars     = {4{b64e_pkg::PAD_CHAR}};
      job_data.last_idx  = 2'd0;
      job_data.final_msg = is_final;
      case (phase_ff)
         b64e_pkg::PH_SECOND: begin
            job_data.chars[0] = b64e_pkg::symbol_of({leftover_ff[1:0], data_byte[7:4]});
            if (is_final) begin
               job_data.chars[1] = b64e_pkg::symbol_of({data_byte[3:0], 2'b00});
               job_data.last_idx = 2'd2;
            end
         end
         b64e_pkg::PH_THIRD: begin
            job_data.chars[0] = b64e_pkg::symbol_of({leftover_ff, data_byte[7:6]});
            job_data.chars[1] = b64e_pkg::symbol_of(data_byte[5:0]);
            job_data.last_idx = 2'd1;
         end
         default: begin
            job_data.chars[0] = b64e_pkg::symbol_of(data_byte[7:2]);
            if (is_final) begin
               job_data.chars[1] = b64e_pkg::symbol_of({data_byte[1:0], 4'b0000});
               job_data.last_idx = 2'd3;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry queue of character runs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64e_pkg::job_type push_data,
   output logic                   full,
   output logic                   head_valid,
   output b64e_pkg::job_type      head_data,
   input  wire logic              pop
);

   b64e_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the queued character runs and sends one character per word through
// an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire b64e_pkg::job_type head_data,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [6:0]             out_char,
   output logic                   last_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, at_end;

   // The output register may take a new character when empty or being drained.
   assign load   = !valid_ff || out_ready;
   assign at_end = (idx_ff == head_data.last_idx);
   assign pop    = load && head_valid && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = head_valid;
         char_in  = head_data.chars[idx_ff];
         last_in  = head_data.final_msg && at_end;
         if (head_valid) begin
            idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign last_char = last_ff;

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// Streaming base64 encoder with a reversed alphabet ('/', '+', '9'..'0', 'z'..'a',
// 'Z'..'A'). Each accepted byte produces the characters it completes: one for the
// first and second byte of a group and two for the third; a byte with tlast set
// flushes the leftover bits and pads the group to four characters with '=', the
// final character carrying tlast, and the next byte starts a new message. One
// character leaves per cycle while rsp_tready is high, so the output channel sets
// the sustained rate; a single byte yields one to four characters. A two-entry
// queue between the byte front end and the character back end lets the input
// keep flowing while characters drain. The first character of a byte is written
// into the queue when the byte is accepted and is presented once it heads the
// queue and the output register is empty or being drained.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Top level: byte front end, run queue and character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // is_final
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] out_char, [7] zero
   output logic            rsp_tlast    // last_char
);

   b64e_pkg::job_type push_data, head_data;
   logic              push, full, head_valid, pop;
   logic [6:0]        out_char;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .data_byte  (req_tdata),
      .is_final   (req_tlast),
      .job_push   (push),
      .job_data   (push_data),
      .job_full   (full)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (out_char),
      .last_char  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

### rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_encoder_assert.svh"

module b64e_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   logic rsp_take, pad_seen;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign pad_seen = (rsp_tdata[6:0] == b64e_pkg::PAD_CHAR);

   // A stalled word holds its value.
   `B64E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // The top bit of an output word is always clear.
   `B64E_ASSERT_IMPLY(a_rsp_msb, clock, reset, rsp_tvalid, !rsp_tdata[7])

   // A pad that does not end the message is followed at once by the closing pad.
   `B64E_ASSERT_NEXT(a_pad_pair, clock, reset, rsp_take && pad_seen && !rsp_tlast,
                     rsp_tvalid && pad_seen && rsp_tlast)

   // Nothing is offered directly after reset.
   `B64E_ASSERT_IMPLY(a_reset_idle, clock, 1'b0, $past(reset), !rsp_tvalid)

   // The input is never refused while the output side is idle and drained.
   `B64E_ASSERT_IMPLY(a_req_ready, clock, reset,
                      $past(!rsp_tvalid) && !rsp_tvalid && $past(!req_tvalid),
                      req_tready)

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
